// ----- src/table_driven_fsm_engine_assert.svh -----
// Assertion macros for the table-driven state machine engine
`ifndef TABLE_DRIVEN_FSM_ENGINE_ASSERT_SVH
`define TABLE_DRIVEN_FSM_ENGINE_ASSERT_SVH

// expr holds at every clock edge out of reset
`define TDFE_ASSERT_ALWAYS(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("tdfe assertion failed");

// ante at one edge implies cons at the next edge
`define TDFE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tdfe assertion failed");

`endif

// ----- src/tdfe_pkg.sv -----
// Types and codes shared by the state machine engine
package tdfe_pkg;

   localparam logic [2:0] OP_SEND     = 3'd0;
   localparam logic [2:0] OP_AUTO     = 3'd1;
   localparam logic [2:0] OP_ADD      = 3'd2;
   localparam logic [2:0] OP_REMOVE   = 3'd3;
   localparam logic [2:0] OP_QUERY    = 3'd4;
   localparam logic [2:0] OP_HISTORY  = 3'd5;

   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_NO_RULE  = 3'd1;
   localparam logic [2:0] ST_GUARD    = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NO_AUTO  = 3'd4;
   localparam logic [2:0] ST_NO_HIST  = 3'd5;

   localparam logic CSR_START_STATE   = 1'b0;
   localparam logic CSR_NONE_EVENT    = 1'b1;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] from_state;
      logic [7:0] event_code;
      logic [7:0] to_state;
      logic       auto_rule;
      logic       fixed_rule;
      logic       guard_pass;
      logic [3:0] history_index;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] current_state;
      logic [7:0] from_out;
      logic [7:0] event_out;
      logic [7:0] target_state;
      logic [5:0] count_out;
   } rsp_type;

   typedef struct packed {
      logic [7:0] from_state;
      logic [7:0] event_code;
      logic [7:0] to_state;
      logic       auto_rule;
      logic       fixed_rule;
   } rule_type;

   typedef struct packed {
      logic [7:0] from_state;
      logic [7:0] event_code;
      logic [7:0] to_state;
   } hist_type;

endpackage

// ----- src/tdfe_ram.sv -----
// Single-port-write, registered-read memory
module tdfe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/table_driven_fsm_engine.sv -----
// Table-driven state machine engine: top level and scan sequencer
// A request is taken only while the engine is idle. Send, process-auto, query and
// remove scan the used rules through one read port, a read state and a check state
// per rule; add, out-of-range operations and a history read with an index past the
// fill go straight to the output state, any other history read first reads the RAM.
// The result sits in an output register until taken. Configuration writes land at
// once; writing the start state also sets the current state.
module table_driven_fsm_engine #(
   parameter int RULE_SLOTS    = 32,
   parameter int HISTORY_SLOTS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tdfe_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tdfe_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);

`include "table_driven_fsm_engine_assert.svh"

   localparam int RIDX_W = $clog2(RULE_SLOTS);
   localparam int CW     = $clog2(RULE_SLOTS + 1);
   localparam int HIDX_W = $clog2(HISTORY_SLOTS);
   localparam int FILL_W = $clog2(HISTORY_SLOTS + 1);
   localparam int SW     = ((HIDX_W > 4) ? HIDX_W : 4) + 2;

   typedef enum logic [2:0] {S_IDLE, S_RD, S_CK, S_HRD, S_DONE, S_OUT} state_type;

   state_type         state_ff;
   tdfe_pkg::req_type req_ff;
   tdfe_pkg::rsp_type res_ff;
   tdfe_pkg::rsp_type res_in;
   tdfe_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;
   logic [7:0]        none_ev_ff, present_ff;
   logic [7:0]        key_from_ff, key_ev_ff;
   logic [CW-1:0]     used_ff, idx_ff, wr_ff, rm_cnt_ff;
   logic              have_exact_ff, have_auto_ff;
   logic [7:0]        exact_to_ff, auto_to_ff;
   logic [HIDX_W-1:0] head_ff;
   logic [FILL_W-1:0] fill_ff;

   logic                  rule_we;
   logic [RIDX_W-1:0]     rule_waddr;
   tdfe_pkg::rule_type    rule_wdata, rule_rdata;
   logic                  hist_we;
   tdfe_pkg::hist_type    hist_wdata, hist_rdata;
   logic [HIDX_W-1:0]     hist_raddr;
   logic [SW-1:0]         slot_sum;
   logic                  hist_ok;
   logic                  m_from, m_exact, m_auto, m_del;
   logic                  found;
   logic [7:0]            match_to;
   logic [2:0]            fin_status;
   logic                  commit;

   tdfe_ram #(.WIDTH($bits(tdfe_pkg::rule_type)), .DEPTH(RULE_SLOTS)) u_rule_ram (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (rule_waddr),
      .wr_data (rule_wdata),
      .rd_addr (idx_ff[RIDX_W-1:0]),
      .rd_data (rule_rdata)
   );

   tdfe_ram #(.WIDTH($bits(tdfe_pkg::hist_type)), .DEPTH(HISTORY_SLOTS)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (head_ff),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // history slot: newest is head-1
   always_comb begin
      slot_sum = SW'(head_ff) + SW'(HISTORY_SLOTS - 1) - SW'(req_payload.history_index);
      if (slot_sum >= SW'(HISTORY_SLOTS)) begin
         slot_sum = slot_sum - SW'(HISTORY_SLOTS);
      end
      hist_raddr = slot_sum[HIDX_W-1:0];
      hist_ok    = SW'(req_payload.history_index) < SW'(fill_ff);
   end

   // result known at acceptance
   always_comb begin
      res_in        = '0;
      res_in.status = tdfe_pkg::ST_NO_RULE;
      case (req_payload.op) inside
         tdfe_pkg::OP_ADD: begin
            res_in.from_out  = req_payload.from_state;
            res_in.event_out = req_payload.event_code;
            if (used_ff < CW'(RULE_SLOTS)) begin
               res_in.status       = tdfe_pkg::ST_DONE;
               res_in.target_state = req_payload.to_state;
            end else begin
               res_in.status = tdfe_pkg::ST_FULL;
            end
         end
         tdfe_pkg::OP_HISTORY: begin
            res_in.count_out = 6'(fill_ff);
            if (!hist_ok) begin
               res_in.status = tdfe_pkg::ST_NO_HIST;
            end
         end
         default: ;
      endcase
   end

   assign m_from  = (rule_rdata.from_state == key_from_ff);
   assign m_exact = m_from && (rule_rdata.event_code == key_ev_ff) && !rule_rdata.auto_rule;
   assign m_auto  = m_from && rule_rdata.auto_rule;
   assign m_del   = m_from && (rule_rdata.event_code == key_ev_ff) && !rule_rdata.fixed_rule;

   always_comb begin
      rule_we    = 1'b0;
      rule_waddr = used_ff[RIDX_W-1:0];
      rule_wdata = '{from_state: req_payload.from_state, event_code: req_payload.event_code,
                     to_state: req_payload.to_state, auto_rule: req_payload.auto_rule,
                     fixed_rule: req_payload.fixed_rule};
      if (state_ff == S_IDLE && req_valid && req_payload.op == tdfe_pkg::OP_ADD
          && used_ff < CW'(RULE_SLOTS)) begin
         rule_we = 1'b1;
      end else if (state_ff == S_CK && req_ff.op == tdfe_pkg::OP_REMOVE && !m_del) begin
         rule_we    = 1'b1;
         rule_waddr = wr_ff[RIDX_W-1:0];
         rule_wdata = rule_rdata;
      end
   end

   always_comb begin
      found    = have_exact_ff || have_auto_ff;
      match_to = have_exact_ff ? exact_to_ff : auto_to_ff;
      commit   = 1'b0;
      case (req_ff.op) inside
         tdfe_pkg::OP_SEND, tdfe_pkg::OP_AUTO: begin
            if (req_ff.op == tdfe_pkg::OP_AUTO && !have_auto_ff) begin
               fin_status = tdfe_pkg::ST_NO_AUTO;
            end else if (!found) begin
               fin_status = tdfe_pkg::ST_NO_RULE;
            end else if (!req_ff.guard_pass) begin
               fin_status = tdfe_pkg::ST_GUARD;
            end else begin
               fin_status = tdfe_pkg::ST_DONE;
               commit     = 1'b1;
            end
         end
         tdfe_pkg::OP_QUERY:  fin_status = found ? tdfe_pkg::ST_DONE : tdfe_pkg::ST_NO_RULE;
         tdfe_pkg::OP_REMOVE: fin_status = tdfe_pkg::ST_DONE;
         default:             fin_status = tdfe_pkg::ST_NO_RULE;
      endcase
      hist_we    = (state_ff == S_DONE) && commit;
      hist_wdata = '{from_state: key_from_ff, event_code: key_ev_ff, to_state: match_to};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         none_ev_ff   <= 8'd255;
         present_ff   <= 8'd0;
         used_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               tdfe_pkg::CSR_START_STATE: present_ff <= csr_wdata;
               tdfe_pkg::CSR_NONE_EVENT:  none_ev_ff <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff        <= req_payload;
                  idx_ff        <= '0;
                  wr_ff         <= '0;
                  rm_cnt_ff     <= '0;
                  have_exact_ff <= 1'b0;
                  have_auto_ff  <= 1'b0;
                  res_ff        <= res_in;
                  key_from_ff   <= (req_payload.op == tdfe_pkg::OP_SEND
                                    || req_payload.op == tdfe_pkg::OP_AUTO)
                                   ? present_ff : req_payload.from_state;
                  key_ev_ff     <= (req_payload.op == tdfe_pkg::OP_AUTO)
                                   ? none_ev_ff : req_payload.event_code;
                  case (req_payload.op) inside
                     tdfe_pkg::OP_ADD: begin
                        if (used_ff < CW'(RULE_SLOTS)) begin
                           used_ff <= used_ff + CW'(1);
                        end
                        state_ff <= S_OUT;
                     end
                     tdfe_pkg::OP_HISTORY: begin
                        state_ff <= hist_ok ? S_HRD : S_OUT;
                     end
                     tdfe_pkg::OP_SEND, tdfe_pkg::OP_AUTO, tdfe_pkg::OP_REMOVE,
                     tdfe_pkg::OP_QUERY: begin
                        state_ff <= (used_ff == '0) ? S_DONE : S_RD;
                     end
                     default: state_ff <= S_OUT;
                  endcase
               end
            end
            S_RD: state_ff <= S_CK;
            S_CK: begin
               if (m_exact && !have_exact_ff) begin
                  have_exact_ff <= 1'b1;
                  exact_to_ff   <= rule_rdata.to_state;
               end
               if (m_auto && !have_auto_ff) begin
                  have_auto_ff <= 1'b1;
                  auto_to_ff   <= rule_rdata.to_state;
               end
               if (req_ff.op == tdfe_pkg::OP_REMOVE) begin
                  if (m_del) begin
                     rm_cnt_ff <= rm_cnt_ff + CW'(1);
                  end else begin
                     wr_ff <= wr_ff + CW'(1);
                  end
               end
               idx_ff <= idx_ff + CW'(1);
               if (idx_ff + CW'(1) == used_ff) begin
                  if (req_ff.op == tdfe_pkg::OP_REMOVE) begin
                     used_ff <= m_del ? wr_ff : wr_ff + CW'(1);
                  end
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_RD;
               end
            end
            S_HRD: begin
               res_ff   <= '{status: tdfe_pkg::ST_DONE, current_state: 8'd0,
                             from_out: hist_rdata.from_state,
                             event_out: hist_rdata.event_code,
                             target_state: hist_rdata.to_state,
                             count_out: res_ff.count_out};
               state_ff <= S_OUT;
            end
            S_DONE: begin
               res_ff <= '{status: fin_status, current_state: 8'd0,
                           from_out: key_from_ff, event_out: key_ev_ff,
                           target_state: (fin_status == tdfe_pkg::ST_DONE
                                          && req_ff.op != tdfe_pkg::OP_REMOVE)
                                         ? match_to : 8'd0,
                           count_out: (req_ff.op == tdfe_pkg::OP_REMOVE)
                                      ? 6'(rm_cnt_ff) : 6'd0};
               if (commit) begin
                  present_ff <= match_to;
                  head_ff    <= (head_ff == HIDX_W'(HISTORY_SLOTS - 1)) ? '0
                                : head_ff + HIDX_W'(1);
                  if (fill_ff != FILL_W'(HISTORY_SLOTS)) begin
                     fill_ff <= fill_ff + FILL_W'(1);
                  end
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff       <= '{status: res_ff.status, current_state: present_ff,
                                    from_out: res_ff.from_out, event_out: res_ff.event_out,
                                    target_state: res_ff.target_state,
                                    count_out: res_ff.count_out};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `TDFE_ASSERT_ALWAYS(a_used_bound, used_ff <= CW'(RULE_SLOTS))
   `TDFE_ASSERT_ALWAYS(a_fill_bound, fill_ff <= FILL_W'(HISTORY_SLOTS))
   `TDFE_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
   `TDFE_ASSERT_ALWAYS(a_tgt_zero, !rsp_valid_ff || rsp_ff.status == tdfe_pkg::ST_DONE
                       || rsp_ff.target_state == 8'd0)

endmodule
